/* rtl/core/w1eis_pkg.sv */
// Shared types, widths and small helper functions for the weight-one Eisenstein block.
package w1eis_pkg;

  localparam int DIV_W = 32;
  localparam int MOD_W = 32;
  localparam int VAL_W = 16;
  localparam int SUM_W = 16;
  localparam int CNT_W = 6;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [1:0] q_mod3;
  } div_rsp_t;

  // (2 * m + b) mod 3
  function automatic logic [1:0] mod3_shift(logic [1:0] m, logic b);
    logic [1:0] r;
    case ({m, b})
      3'b000:  r = 2'd0;
      3'b001:  r = 2'd1;
      3'b010:  r = 2'd2;
      3'b011:  r = 2'd0;
      3'b100:  r = 2'd1;
      3'b101:  r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] mod3_inc(logic [1:0] m);
    return (m == 2'd2) ? 2'd0 : m + 2'd1;
  endfunction

  function automatic logic [SUM_W-1:0] chi3_inc(logic [1:0] m);
    logic [SUM_W-1:0] r;
    case (m)
      2'd1:    r = SUM_W'(1);
      2'd2:    r = '1;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [SUM_W-1:0] chi4_inc(logic [1:0] low);
    logic [SUM_W-1:0] r;
    case (low)
      2'd1:    r = SUM_W'(1);
      2'd3:    r = '1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/w1eis_div.sv */
// Shared radix-2 restoring divider, one quotient bit per cycle, with quotient mod 3 tracking.
module w1eis_div
  import w1eis_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output div_rsp_t         rsp_o,
  output logic [DIV_W-1:0] quot_o,
  output logic [DIV_W-1:0] rem_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] dvd_q, dvd_d;
  logic [DIV_W-1:0] dvs_q, dvs_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] quot_q, quot_d;
  logic [1:0]       qm3_q, qm3_d;

  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   diff;
  logic             qbit;

  assign rem_sh = {rem_q, dvd_q[DIV_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign qbit   = ~diff[DIV_W];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    qm3_d  = qm3_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.nbits;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
      quot_d = '0;
      qm3_d  = 2'd0;
    end else if (busy_q) begin
      dvd_d  = {dvd_q[DIV_W-2:0], 1'b0};
      rem_d  = qbit ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      quot_d = {quot_q[DIV_W-2:0], qbit};
      qm3_d  = mod3_shift(qm3_q, qbit);
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    dvs_q  <= dvs_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
    qm3_q  <= qm3_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.q_mod3 = qm3_q;
  assign quot_o       = quot_q;
  assign rem_o        = rem_q;

endmodule

/* rtl/core/weight1_eisenstein_coefficients.sv */
// Top level: divisor-trial sequencer around a shared divider, with output register.
//
//   channel  dir  handshake                     payload
//   s_axis   in   s_axis_tvalid/tready          tdata[INDEX_BITS-1:0] = index
//   m_axis   out  m_axis_tvalid/tready          tdata[31:0] = e3_coeff, [63:32] = e4_coeff
//   cfg      in   cfg_wr_en_i                   cfg_wr_data_i = modulus
//
// Index zero: only the two reductions. Otherwise (floor(sqrt(n)) + 1) trial divisions,
// then two reductions by the modulus (done without the divider with modulus zero); the
// trial divisions and the reductions by a nonzero modulus run on the single shared divider.
// Reset leaves the modulus at 2 and the block idle; no clearing pass.
// Input is taken only when idle; a held result blocks the next result, not the next input.
module weight1_eisenstein_coefficients
  import w1eis_pkg::*;
#(
  parameter int INDEX_BITS = 20
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [INDEX_BITS-1:0] index
  input  logic [((INDEX_BITS+7)/8)*8-1:0]      s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [31:0] e3_coeff, [63:32] e4_coeff
  output logic [2*MOD_W-1:0]                   m_axis_tdata,
  input  logic                                 cfg_wr_en_i,
  input  logic [MOD_W-1:0]                     cfg_wr_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_TRIAL, ST_TWAIT, ST_RED3, ST_R3WAIT, ST_RED4, ST_R4WAIT, ST_DONE
  } state_e;

  state_e                  state_q, state_d;
  logic [INDEX_BITS-1:0]   n_q, n_d;
  logic [INDEX_BITS-1:0]   d_q, d_d;
  logic [1:0]              dm3_q, dm3_d;
  logic [SUM_W-1:0]        s3_q, s3_d;
  logic [SUM_W-1:0]        s4_q, s4_d;
  logic [VAL_W-1:0]        val3_q, val3_d;
  logic [VAL_W-1:0]        val4_q, val4_d;
  logic [MOD_W-1:0]        e3_q, e3_d;
  logic [MOD_W-1:0]        e4_q, e4_d;
  logic                    m_valid_q, m_valid_d;
  logic [2*MOD_W-1:0]      m_data_q, m_data_d;
  logic [MOD_W-1:0]        modulus_q;

  div_req_t                div_req;
  div_rsp_t                div_rsp;
  logic [DIV_W-1:0]        div_dvd;
  logic [DIV_W-1:0]        div_dvs;
  logic [DIV_W-1:0]        div_quot;
  logic [DIV_W-1:0]        div_rem;
  logic [INDEX_BITS-1:0]   quot;
  logic                    mod_zero;

  assign quot     = div_quot[INDEX_BITS-1:0];
  assign mod_zero = (modulus_q == '0);

  always_comb begin
    div_req.start = (state_q == ST_TRIAL) ||
                    (((state_q == ST_RED3) || (state_q == ST_RED4)) && !mod_zero);
    div_req.nbits = (state_q == ST_TRIAL) ? CNT_W'(INDEX_BITS) : CNT_W'(VAL_W);
    if (state_q == ST_TRIAL) begin
      div_dvd = DIV_W'(n_q) << (DIV_W - INDEX_BITS);
      div_dvs = DIV_W'(d_q);
    end else begin
      div_dvd = (state_q == ST_RED4) ? {val4_q, {(DIV_W-VAL_W){1'b0}}}
                                     : {val3_q, {(DIV_W-VAL_W){1'b0}}};
      div_dvs = modulus_q;
    end
  end

  w1eis_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .rsp_o      (div_rsp),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    d_d       = d_q;
    dm3_d     = dm3_q;
    s3_d      = s3_q;
    s4_d      = s4_q;
    val3_d    = val3_q;
    val4_d    = val4_q;
    e3_d      = e3_q;
    e4_d      = e4_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          n_d = s_axis_tdata[INDEX_BITS-1:0];
          if (s_axis_tdata[INDEX_BITS-1:0] == '0) begin
            val3_d  = VAL_W'(1);
            val4_d  = VAL_W'(1);
            state_d = ST_RED3;
          end else begin
            d_d     = INDEX_BITS'(1);
            dm3_d   = 2'd1;
            s3_d    = '0;
            s4_d    = '0;
            state_d = ST_TRIAL;
          end
        end
      end
      ST_TRIAL: begin
        state_d = ST_TWAIT;
      end
      ST_TWAIT: begin
        if (div_rsp.done) begin
          if (quot < d_q) begin
            val3_d  = VAL_W'({s3_q, 2'b00}) + VAL_W'({s3_q, 1'b0});
            val4_d  = VAL_W'({s4_q, 2'b00});
            state_d = ST_RED3;
          end else begin
            if (div_rem == '0) begin
              s3_d = s3_q + chi3_inc(dm3_q)
                   + ((quot != d_q) ? chi3_inc(div_rsp.q_mod3) : SUM_W'(0));
              s4_d = s4_q + chi4_inc(d_q[1:0])
                   + ((quot != d_q) ? chi4_inc(quot[1:0]) : SUM_W'(0));
            end
            d_d     = d_q + INDEX_BITS'(1);
            dm3_d   = mod3_inc(dm3_q);
            state_d = ST_TRIAL;
          end
        end
      end
      ST_RED3: begin
        if (mod_zero) begin
          e3_d    = MOD_W'(val3_q);
          state_d = ST_RED4;
        end else begin
          state_d = ST_R3WAIT;
        end
      end
      ST_R3WAIT: begin
        if (div_rsp.done) begin
          e3_d    = div_rem;
          state_d = ST_RED4;
        end
      end
      ST_RED4: begin
        if (mod_zero) begin
          e4_d    = MOD_W'(val4_q);
          state_d = ST_DONE;
        end else begin
          state_d = ST_R4WAIT;
        end
      end
      ST_R4WAIT: begin
        if (div_rsp.done) begin
          e4_d    = div_rem;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_data_d  = {e4_q, e3_q};
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      n_q       <= '0;
      d_q       <= '0;
      dm3_q     <= '0;
      s3_q      <= '0;
      s4_q      <= '0;
      val3_q    <= '0;
      val4_q    <= '0;
      e3_q      <= '0;
      e4_q      <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      state_q   <= state_d;
      n_q       <= n_d;
      d_q       <= d_d;
      dm3_q     <= dm3_d;
      s3_q      <= s3_d;
      s4_q      <= s4_d;
      val3_q    <= val3_d;
      val4_q    <= val4_d;
      e3_q      <= e3_d;
      e4_q      <= e4_d;
      m_valid_q <= m_valid_d;
      m_data_q  <= m_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MOD_W'(2);
    end else if (cfg_wr_en_i) begin
      modulus_q <= cfg_wr_data_i;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

/* rtl/core/w1eis_chk.sv */
// Port-level checker for the weight-one Eisenstein block, bound to the top level.
module w1eis_chk
  import w1eis_pkg::*;
(
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [2*MOD_W-1:0]              m_axis_tdata
);

  logic s_txn;

  assign s_txn = s_axis_tvalid && s_axis_tready;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // busy after taking a transaction
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_txn |=> !s_axis_tready)
    else $error("input taken while still working");

  // a new result appears only as the sequencer finishes
  a_rise_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without work");

  // keep a pending result while the sequencer is busy
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready && !s_axis_tready |=> m_axis_tvalid)
    else $error("result dropped");

endmodule

bind weight1_eisenstein_coefficients w1eis_chk u_chk (.*);

/* test/tb.sv */
// Self-checking testbench for the weight-one Eisenstein coefficient block.
`timescale 1ns / 1ps

module tb
  import w1eis_pkg::*;
();

  localparam int INDEX_BITS = 20;
  localparam int IN_W = ((INDEX_BITS + 7) / 8) * 8;
  localparam int STALL_LIMIT = 100000;
  localparam int RANDOM_PHASES = 12;
  localparam int ITEMS_PER_PHASE = 48;
  localparam int SETTLE_CYCLES = 50;
  localparam logic [INDEX_BITS-1:0] DIRECTED_INDEXES [16] = '{
    20'd0, 20'd1, 20'd2, 20'd3, 20'd4, 20'd5, 20'd9, 20'd12, 20'd16, 20'd25, 20'd49,
    20'd65, 20'd720720, 20'hFFFFF, 20'h80000, 20'd1046529
  };

  class coeff_scoreboard;
    typedef struct {
      logic [INDEX_BITS-1:0] index;
      logic [MOD_W-1:0]      e3;
      logic [MOD_W-1:0]      e4;
    } coeff_pair_t;

    coeff_pair_t      expected_coeffs[$];
    logic [MOD_W-1:0] modulus = 2;
    int               failures = 0;

    function void set_modulus(logic [MOD_W-1:0] m);
      modulus = m;
    endfunction

    function int pending();
      return expected_coeffs.size();
    endfunction

    function longint char_mod3(longint unsigned d);
      longint unsigned r = d % 3;
      return (r == 1) ? 1 : ((r == 2) ? -1 : 0);
    endfunction

    function longint char_mod4(longint unsigned d);
      longint unsigned r = d % 4;
      return (r == 1) ? 1 : ((r == 3) ? -1 : 0);
    endfunction

    function logic [MOD_W-1:0] reduce(longint v);
      longint m;
      longint r;
      if (modulus == 0) return v[MOD_W-1:0];
      m = longint'(modulus);
      r = v % m;
      if (r < 0) r += m;
      return r[MOD_W-1:0];
    endfunction

    function void note_index(logic [INDEX_BITS-1:0] n);
      coeff_pair_t     p;
      longint          s3;
      longint          s4;
      longint          v3;
      longint          v4;
      longint unsigned d;
      longint unsigned e;
      s3 = 0;
      s4 = 0;
      if (n == 0) begin
        v3 = 1;
        v4 = 1;
      end else begin
        for (d = 1; d * d <= n; d++) begin
          if (n % d == 0) begin
            e = n / d;
            s3 += char_mod3(d);
            s4 += char_mod4(d);
            if (e != d) begin
              s3 += char_mod3(e);
              s4 += char_mod4(e);
            end
          end
        end
        v3 = 6 * s3;
        v4 = 4 * s4;
      end
      p.index = n;
      p.e3 = reduce(v3);
      p.e4 = reduce(v4);
      expected_coeffs = {expected_coeffs, p};
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function void check_result(logic [2*MOD_W-1:0] data);
      coeff_pair_t p;
      if (expected_coeffs.size() == 0) begin
        report($sformatf("result %h with nothing outstanding", data));
        return;
      end
      p = expected_coeffs.pop_front();
      if (data[MOD_W-1:0] !== p.e3)
        report($sformatf("index %0d e3_coeff expected %0d actual %0d",
                         p.index, p.e3, data[MOD_W-1:0]));
      if (data[2*MOD_W-1:MOD_W] !== p.e4)
        report($sformatf("index %0d e4_coeff expected %0d actual %0d",
                         p.index, p.e4, data[2*MOD_W-1:MOD_W]));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [2*MOD_W-1:0]   m_axis_tdata;
  logic                 cfg_wr_en = 1'b0;
  logic [MOD_W-1:0]     cfg_wr_data = '0;
  int                   send_idle_pct = 21;
  int                   recv_idle_pct = 71;
  int                   idle_cycles = 0;
  coeff_scoreboard      sb = new();

  weight1_eisenstein_coefficients #(
    .INDEX_BITS(INDEX_BITS)
  ) i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_wr_en_i  (cfg_wr_en),
    .cfg_wr_data_i(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) sb.note_index(s_axis_tdata[INDEX_BITS-1:0]);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_index(input logic [INDEX_BITS-1:0] n);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'(n);
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Drain every outstanding transaction before touching the modulus
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_modulus(input logic [MOD_W-1:0] m);
    drain();
    repeat (8) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_modulus(m);
  endtask

  initial begin
    logic [MOD_W-1:0]      m;
    logic [INDEX_BITS-1:0] n;
    int                    pick;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_index(INDEX_BITS'(0));
    send_index(INDEX_BITS'(1));
    send_index(INDEX_BITS'(6));
    write_modulus(0);
    foreach (DIRECTED_INDEXES[i]) send_index(DIRECTED_INDEXES[i]);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 4) begin
        send_idle_pct = 71;
        recv_idle_pct = 21;
      end else if (phase == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase)
        0:       m = 1;
        1:       m = 3;
        2:       m = 32'hFFFF_FFFF;
        3:       m = 5;
        4:       m = $urandom_range(64, 2);
        5:       m = 0;
        6:       m = $urandom_range(32'hFFFF_FFFF, 2);
        7:       m = 2;
        8:       m = 12;
        9:       m = 32'd4294967291;
        10:      m = 7;
        default: m = $urandom();
      endcase
      write_modulus(m);
      // Keep most indexes small: the trial loop runs to the square root
      repeat (ITEMS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 80) n = INDEX_BITS'($urandom_range(1023));
        else if (pick < 98) n = INDEX_BITS'($urandom_range(4095));
        else n = INDEX_BITS'($urandom());
        send_index(n);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/w1eis_pkg.sv
rtl/core/w1eis_div.sv
rtl/core/weight1_eisenstein_coefficients.sv
rtl/core/w1eis_chk.sv
test/tb.sv
